// ===== rtl/core/min_jerk_servo_pulse_planner_core_defines.svh =====
// Assertion macros shared by the planner RTL.
// No dependencies.
`ifndef MIN_JERK_SERVO_PULSE_PLANNER_CORE_DEFINES_SVH
`define MIN_JERK_SERVO_PULSE_PLANNER_CORE_DEFINES_SVH
`define MJP_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define MJP_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/mjp_pkg.sv =====
// Planner package: widths, constants, state type, pulse function.
// No dependencies.
package mjp_pkg;
  localparam int NumLegs = 4;
  localparam int JointsPerLeg = 3;
  localparam int NumServo = NumLegs * JointsPerLeg;
  localparam int LegW = 2;
  localparam int ServoW = $clog2(NumServo);
  localparam logic [15:0] AngleMax = 16'd46080;
  localparam logic [10:0] PulseMin = 11'd1000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LEG, ST_DIV, ST_POLY, ST_JRD, ST_JMUL, ST_JPULSE, ST_JEMIT, ST_NEXT
  } state_t;

  typedef struct packed {
    logic start;
    logic [15:0] num;
    logic [15:0] den;
  } div_req_t;

  function automatic logic [15:0] clamp16(input logic [15:0] a);
    return (a > AngleMax) ? AngleMax : a;
  endfunction

  // pulse = 1000 + floor((a*1000+23040)/46080), reciprocal with correction
  function automatic logic [10:0] pulse_of(input logic [15:0] a);
    logic [25:0] n;
    logic [10:0] q;
    logic [47:0] p;
    n = 26'(a) * 26'd1000 + 26'd23040;
    p = 48'(n) * 48'd5965232;
    q = 11'(p >> 38);
    if (n - 26'(q) * 26'd46080 >= 26'd46080) q = q + 11'd1;
    return PulseMin + q;
  endfunction
endpackage

// ===== rtl/core/min_jerk_servo_pulse_planner_core.sv =====
// Minimum-jerk servo pulse planner: top level with state memories and sequencer.
// Depends on mjp_pkg, mjp_div and the defines header.
// Usage: in_ channel carries a move (in_mode=1) or a tick (in_mode=0).
// A move is accepted, then the leg's three joint entries are written in turn
// with in_ready low; it gives no result.
// A tick walks all legs; an interpolating leg runs a serial divide and a
// polynomial, then each joint is read from memory, blended (a resting leg
// takes its target), made into a pulse, compared with its last one and emitted.
// Changed pulses leave on the out_ channel, last_of_tick marks the final one.
// A leg on its final step makes a second pass over its joints at the
// target angles.
// One transaction is worked at a time; in_ready is low while busy.
// Output is a register: a stalled receiver holds the walk at that joint.
// Reset clears control state, the per-leg step registers and the joint
// valid bits; joint memories read as zero until written.
`include "min_jerk_servo_pulse_planner_core_defines.svh"
module min_jerk_servo_pulse_planner_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [1:0]  in_leg,
  input  logic [15:0] in_start_joint0,
  input  logic [15:0] in_start_joint1,
  input  logic [15:0] in_start_joint2,
  input  logic [15:0] in_target_joint0,
  input  logic [15:0] in_target_joint1,
  input  logic [15:0] in_target_joint2,
  input  logic [15:0] in_move_steps,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_leg,
  output logic [1:0]  out_joint,
  output logic [10:0] out_pulse_us,
  output logic        out_last_of_tick
);
  localparam int SW = mjp_pkg::ServoW;

  // joint memory: {start, target, last_pulse}
  logic [42:0] jmem [mjp_pkg::NumServo];
  logic [mjp_pkg::NumServo-1:0] jval_r;
  logic [15:0] tot_r [mjp_pkg::NumLegs];
  logic [15:0] idx_r [mjp_pkg::NumLegs];

  mjp_pkg::state_t st_r, st_nxt;
  logic [1:0] leg_r, leg_nxt;
  logic [1:0] jn_r, jn_nxt;
  logic       fin_r, fin_nxt;   // target pass of a final step
  logic       act_r, act_nxt;   // leg interpolating
  logic [2:0] pc_r, pc_nxt;
  logic [16:0] s_r, s2_r, s3_r, s4_r, s5_r;
  logic signed [20:0] h_r;
  logic [42:0] rd_r;
  logic signed [16:0] a_r;
  logic [10:0] pul_r;
  logic        ov_r;
  logic [1:0]  ol_r, oj_r;
  logic [10:0] op_r;
  logic        olast_r;
  logic [1:0]  ml_r;
  logic [2:0]  mj_r;
  logic        mv_r;
  logic [15:0] ms_r [3];
  logic [15:0] mt_r [3];
  mjp_pkg::div_req_t dreq;
  logic        ddone;
  logic [15:0] dq;
  logic [SW-1:0] jaddr;
  logic [SW-1:0] maddr;
  logic        jrd_en, jwr_en;
  logic [SW-1:0] wraddr;
  logic [42:0] wrdata;
  logic [33:0] mul;
  logic [16:0] ma, mb;
  logic signed [37:0] prod;
  logic signed [17:0] diff;
  logic signed [21:0] blended;
  logic [15:0] ang;
  logic        emit_w;

  assign jaddr = SW'({2'b0, leg_r} * 4'(mjp_pkg::JointsPerLeg) + {2'b0, jn_r});
  assign maddr = SW'({2'b0, ml_r} * 4'(mjp_pkg::JointsPerLeg) + {2'b0, mj_r[1:0]});
  assign mul = 34'(ma) * 34'(mb);

  always_comb begin
    ma = s_r; mb = s_r;
    case (pc_r)
      3'd1: begin ma = s2_r; mb = s_r; end
      3'd2: begin ma = s2_r; mb = s2_r; end
      3'd3: begin ma = s3_r; mb = s2_r; end
      default: begin ma = s_r; mb = s_r; end
    endcase
  end

  assign diff = 18'($signed({2'b0, rd_r[26:11]})) - 18'($signed({2'b0, rd_r[42:27]}));
  assign prod = 38'(diff) * 38'(h_r);
  assign blended = 22'($signed({6'b0, rd_r[42:27]})) + 22'(prod >>> 16);
  assign ang = blended < 0 ? 16'd0 :
               (blended > 22'sd46080 ? mjp_pkg::AngleMax : blended[15:0]);
  assign emit_w = pul_r != rd_r[10:0];

  always_comb begin
    st_nxt = st_r; leg_nxt = leg_r; jn_nxt = jn_r; fin_nxt = fin_r; act_nxt = act_r;
    pc_nxt = pc_r;
    dreq = '0; jrd_en = 1'b0; jwr_en = 1'b0; wraddr = jaddr;
    wrdata = {rd_r[42:11], pul_r};
    in_ready = 1'b0;
    case (st_r)
      mjp_pkg::ST_IDLE: begin
        in_ready = !mv_r;
        if (in_valid && !mv_r && !in_mode) begin
          st_nxt = mjp_pkg::ST_LEG; leg_nxt = '0;
        end
      end
      mjp_pkg::ST_LEG: begin
        jn_nxt = '0; fin_nxt = 1'b0;
        act_nxt = tot_r[leg_r] > 16'd1 && idx_r[leg_r] < tot_r[leg_r];
        if (tot_r[leg_r] > 16'd1 && idx_r[leg_r] < tot_r[leg_r]) begin
          dreq.start = 1'b1; dreq.num = idx_r[leg_r]; dreq.den = tot_r[leg_r];
          st_nxt = mjp_pkg::ST_DIV;
        end else st_nxt = mjp_pkg::ST_JRD;
      end
      mjp_pkg::ST_DIV: if (ddone) begin
        st_nxt = mjp_pkg::ST_POLY; pc_nxt = '0;
      end
      mjp_pkg::ST_POLY: begin
        pc_nxt = pc_r + 3'd1;
        if (pc_r == 3'd4) st_nxt = mjp_pkg::ST_JRD;
      end
      mjp_pkg::ST_JRD: begin
        jrd_en = 1'b1; st_nxt = mjp_pkg::ST_JMUL;
      end
      mjp_pkg::ST_JMUL: st_nxt = mjp_pkg::ST_JPULSE;
      mjp_pkg::ST_JPULSE: st_nxt = mjp_pkg::ST_JEMIT;
      mjp_pkg::ST_JEMIT: begin
        if (!ov_r || out_ready) begin
          if (emit_w) jwr_en = 1'b1;
          if (jn_r == 2'(mjp_pkg::JointsPerLeg - 1)) begin
            jn_nxt = '0;
            if (act_r && !fin_r &&
                32'(idx_r[leg_r]) + 32'd1 >= 32'(tot_r[leg_r])) begin
              fin_nxt = 1'b1; st_nxt = mjp_pkg::ST_JRD;
            end else st_nxt = mjp_pkg::ST_NEXT;
          end else begin
            jn_nxt = jn_r + 2'd1; st_nxt = mjp_pkg::ST_JRD;
          end
        end
      end
      mjp_pkg::ST_NEXT: begin
        if (leg_r == 2'(mjp_pkg::NumLegs - 1)) begin
          if (!ov_r || out_ready) begin
            st_nxt = mjp_pkg::ST_IDLE; in_ready = 1'b0;
          end
        end else begin
          leg_nxt = leg_r + 2'd1; st_nxt = mjp_pkg::ST_LEG;
        end
      end
      default: st_nxt = mjp_pkg::ST_IDLE;
    endcase
  end

  // pending emission is held in a staging slot so last_of_tick can be known
  logic       pend_r;
  logic [1:0] pl_r, pj_r;
  logic [10:0] pp_r;
  logic       take;
  logic       oload;
  assign take = !ov_r || out_ready;
  assign oload = pend_r && take &&
                 ((st_r == mjp_pkg::ST_JEMIT && emit_w) ||
                  (st_r == mjp_pkg::ST_NEXT && leg_r == 2'(mjp_pkg::NumLegs - 1)));

  always_ff @(posedge clk) begin
    if (jrd_en) begin
      rd_r <= jval_r[jaddr] ? jmem[jaddr] : '0;
    end
    if (jwr_en) jmem[wraddr] <= wrdata;
    if (mv_r) begin
      if (jval_r[maddr]) begin
        jmem[maddr][42:11] <=
          {mjp_pkg::clamp16(mj_r < 3'd3 ? ms_r[mj_r[1:0]] : 16'd0),
           mjp_pkg::clamp16(mj_r < 3'd3 ? mt_r[mj_r[1:0]] : 16'd0)};
      end else begin
        jmem[maddr] <=
          {mjp_pkg::clamp16(mj_r < 3'd3 ? ms_r[mj_r[1:0]] : 16'd0),
           mjp_pkg::clamp16(mj_r < 3'd3 ? mt_r[mj_r[1:0]] : 16'd0), 11'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == mjp_pkg::ST_POLY) begin
      case (pc_r)
        3'd0: s2_r <= mul[32:16];
        3'd1: s3_r <= mul[32:16];
        3'd2: s4_r <= mul[32:16];
        3'd3: s5_r <= mul[32:16];
        default: h_r <= 21'(10 * $signed({4'b0, s3_r}) - 15 * $signed({4'b0, s4_r})
                           + 6 * $signed({4'b0, s5_r}));
      endcase
    end
    if (ddone) s_r <= {1'b0, dq};
    if (st_r == mjp_pkg::ST_JMUL) a_r <= act_r && !fin_r ? {1'b0, ang} : {1'b0, rd_r[26:11]};
    if (st_r == mjp_pkg::ST_JPULSE) pul_r <= mjp_pkg::pulse_of(a_r[15:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mjp_pkg::ST_IDLE; leg_r <= '0; jn_r <= '0; fin_r <= 1'b0; act_r <= 1'b0;
      pc_r <= '0; ov_r <= 1'b0; pend_r <= 1'b0; mv_r <= 1'b0;
      ml_r <= '0; mj_r <= '0; jval_r <= '0;
      for (int l = 0; l < mjp_pkg::NumLegs; l++) begin
        tot_r[l] <= '0; idx_r[l] <= '0;
      end
    end else begin
      st_r <= st_nxt; leg_r <= leg_nxt; jn_r <= jn_nxt; fin_r <= fin_nxt;
      act_r <= act_nxt; pc_r <= pc_nxt;
      if (in_valid && in_ready && in_mode && 32'(in_leg) < mjp_pkg::NumLegs) begin
        mv_r <= 1'b1; ml_r <= in_leg; mj_r <= '0;
        ms_r[0] <= in_start_joint0; ms_r[1] <= in_start_joint1; ms_r[2] <= in_start_joint2;
        mt_r[0] <= in_target_joint0; mt_r[1] <= in_target_joint1;
        mt_r[2] <= in_target_joint2;
        tot_r[in_leg] <= in_move_steps; idx_r[in_leg] <= '0;
      end else if (mv_r) begin
        jval_r[maddr] <= 1'b1;
        mj_r <= mj_r + 3'd1;
        if (32'(mj_r) == mjp_pkg::JointsPerLeg - 1) mv_r <= 1'b0;
      end
      if (jwr_en) jval_r[wraddr] <= 1'b1;
      if (st_r == mjp_pkg::ST_JEMIT && take && jn_r == 2'(mjp_pkg::JointsPerLeg - 1)
          && act_r && !fin_r) begin
        if (32'(idx_r[leg_r]) + 32'd1 >= 32'(tot_r[leg_r])) begin
          tot_r[leg_r] <= '0; idx_r[leg_r] <= '0;
        end else idx_r[leg_r] <= idx_r[leg_r] + 16'd1;
      end
      // output stage: a pending pulse is released when the next one or tick end is known
      if (oload) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (st_r == mjp_pkg::ST_JEMIT && take && emit_w) begin
        if (pend_r) begin
          ol_r <= pl_r; oj_r <= pj_r; op_r <= pp_r; olast_r <= 1'b0;
        end
        pend_r <= 1'b1; pl_r <= leg_r; pj_r <= jn_r; pp_r <= pul_r;
      end else if (st_r == mjp_pkg::ST_NEXT && leg_r == 2'(mjp_pkg::NumLegs - 1) && take) begin
        if (pend_r) begin
          ol_r <= pl_r; oj_r <= pj_r; op_r <= pp_r; olast_r <= 1'b1;
        end
        pend_r <= 1'b0;
      end
    end
  end

  mjp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quo(dq));

  assign out_valid = ov_r;
  assign out_leg = ol_r;
  assign out_joint = oj_r;
  assign out_pulse_us = op_r;
  assign out_last_of_tick = olast_r;

  `MJP_ASSERT_IMP(a_pulse_range, out_valid, out_pulse_us >= 11'd1000 && out_pulse_us <= 11'd2000)
  `MJP_ASSERT_IMP(a_idle_no_pend, st_r == mjp_pkg::ST_IDLE, !pend_r)
  `MJP_ASSERT_NXT(a_hold_out, out_valid && !out_ready, out_valid && $stable(out_pulse_us))
  `MJP_ASSERT_IMP(a_no_move_busy, mv_r, st_r == mjp_pkg::ST_IDLE)
endmodule

// ===== rtl/core/mjp_div.sv =====
// Restoring divider: floor(num*65536/den), one quotient bit per cycle.
// Depends on mjp_pkg.
module mjp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mjp_pkg::div_req_t req,
  output logic              done,
  output logic [15:0]       quo
);
  logic [16:0] rem_r, rem_nxt;
  logic [31:0] num_r, num_nxt;
  logic [15:0] den_r, quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;

  always_comb begin
    rem_nxt = rem_r; num_nxt = num_r; quo_nxt = quo_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, num_r[31]} - {2'b0, den_r};
    if (req.start) begin
      rem_nxt = '0; num_nxt = {req.num, 16'h0}; quo_nxt = '0; cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[30:0], 1'b0};
      if (!trial[17]) begin
        rem_nxt = trial[16:0]; quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], num_r[31]}; quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt; done_r <= done_nxt;
    end
    rem_r <= rem_nxt; num_r <= num_nxt; quo_r <= quo_nxt;
    if (req.start) den_r <= req.den;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

// ===== test/tb_min_jerk_servo_pulse_planner_core.sv =====
// Testbench for min_jerk_servo_pulse_planner_core: random move and tick transactions
// checked against an in-bench trajectory and pulse predictor. Depends on mjp_pkg and the RTL.
module tb_min_jerk_servo_pulse_planner_core;

  typedef struct {
    logic        mode;
    logic [1:0]  leg;
    logic [15:0] st [3];
    logic [15:0] tg [3];
    logic [15:0] steps;
  } cmd_t;

  typedef struct {
    logic [1:0]  leg;
    logic [1:0]  joint;
    logic [10:0] pulse;
    logic        last;
  } pulse_wr_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic in_mode = 0;
  logic [1:0] in_leg = 0;
  logic [15:0] in_start_joint0 = 0, in_start_joint1 = 0, in_start_joint2 = 0;
  logic [15:0] in_target_joint0 = 0, in_target_joint1 = 0, in_target_joint2 = 0;
  logic [15:0] in_move_steps = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_leg, out_joint;
  logic [10:0] out_pulse_us;
  logic out_last_of_tick;

  cmd_t cmd_q[$];
  pulse_wr_t pulse_q[$];
  int errors = 0;
  int send_idle = 22, recv_idle = 52;
  bit stim_done = 0;

  logic [15:0] p_total [mjp_pkg::NumLegs];
  logic [15:0] p_index [mjp_pkg::NumLegs];
  logic [15:0] p_start [mjp_pkg::NumServo];
  logic [15:0] p_target [mjp_pkg::NumServo];
  logic [10:0] p_last [mjp_pkg::NumServo];

  min_jerk_servo_pulse_planner_core i_dut (.*);

  always #5 clk = ~clk;

  function automatic logic [10:0] exp_pulse(logic [15:0] a);
    longint x;
    x = a;
    return 11'(1000 + (x * 1000 + 23040) / 46080);
  endfunction

  function automatic logic [15:0] sat_angle(logic [15:0] a);
    return (a > 16'd46080) ? 16'd46080 : a;
  endfunction

  function automatic void push_pulse(int leg, int j, logic [10:0] p);
    pulse_wr_t w;
    int k;
    k = leg * mjp_pkg::JointsPerLeg + j;
    if (p == p_last[k]) return;
    p_last[k] = p;
    w.leg = 2'(leg);
    w.joint = 2'(j);
    w.pulse = p;
    w.last = 0;
    pulse_q.push_back(w);
  endfunction

  function automatic void predict(cmd_t c);
    longint s, s2, s3, s4, s5, h, d, pr, a;
    int n0, k;
    if (c.mode) begin
      for (int j = 0; j < mjp_pkg::JointsPerLeg; j++) begin
        p_start[c.leg * mjp_pkg::JointsPerLeg + j] = sat_angle(c.st[j]);
        p_target[c.leg * mjp_pkg::JointsPerLeg + j] = sat_angle(c.tg[j]);
      end
      p_total[c.leg] = c.steps;
      p_index[c.leg] = 0;
      return;
    end
    n0 = pulse_q.size();
    for (int i = 0; i < mjp_pkg::NumLegs; i++) begin
      if (p_total[i] > 1 && p_index[i] < p_total[i]) begin
        s = (longint'(p_index[i]) << 16) / p_total[i];
        s2 = (s * s) >>> 16;
        s3 = (s2 * s) >>> 16;
        s4 = (s2 * s2) >>> 16;
        s5 = (s3 * s2) >>> 16;
        h = 10 * s3 - 15 * s4 + 6 * s5;
        for (int j = 0; j < mjp_pkg::JointsPerLeg; j++) begin
          k = i * mjp_pkg::JointsPerLeg + j;
          d = longint'(p_target[k]) - longint'(p_start[k]);
          pr = d * h;
          pr = (pr >= 0) ? pr / 65536 : -((-pr + 65535) / 65536);
          a = longint'(p_start[k]) + pr;
          if (a < 0) a = 0;
          if (a > 46080) a = 46080;
          push_pulse(i, j, exp_pulse(16'(a)));
        end
        p_index[i] = p_index[i] + 1;
        if (p_index[i] >= p_total[i]) begin
          for (int j = 0; j < mjp_pkg::JointsPerLeg; j++)
            push_pulse(i, j, exp_pulse(p_target[i * mjp_pkg::JointsPerLeg + j]));
          p_total[i] = 0;
          p_index[i] = 0;
        end
      end else begin
        for (int j = 0; j < mjp_pkg::JointsPerLeg; j++)
          push_pulse(i, j, exp_pulse(p_target[i * mjp_pkg::JointsPerLeg + j]));
      end
    end
    if (pulse_q.size() > n0) pulse_q[pulse_q.size() - 1].last = 1;
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd46080;
      2: return 16'($urandom_range(46081, 65535));
      default: return 16'($urandom_range(0, 46080));
    endcase
  endfunction

  function automatic cmd_t make_move(int leg, int steps);
    cmd_t c;
    c.mode = 1;
    c.leg = 2'(leg);
    for (int j = 0; j < 3; j++) begin
      c.st[j] = rand_angle();
      c.tg[j] = rand_angle();
    end
    c.steps = 16'(steps);
    return c;
  endfunction

  function automatic cmd_t make_tick();
    cmd_t c;
    c.mode = 0;
    c.leg = 2'($urandom);
    for (int j = 0; j < 3; j++) begin
      c.st[j] = 16'($urandom);
      c.tg[j] = 16'($urandom);
    end
    c.steps = 16'($urandom);
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid) predict(cmd_q.pop_front());
        if (cmd_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          in_valid <= 1;
          in_mode <= cmd_q[0].mode;
          in_leg <= cmd_q[0].leg;
          in_start_joint0 <= cmd_q[0].st[0];
          in_start_joint1 <= cmd_q[0].st[1];
          in_start_joint2 <= cmd_q[0].st[2];
          in_target_joint0 <= cmd_q[0].tg[0];
          in_target_joint1 <= cmd_q[0].tg[1];
          in_target_joint2 <= cmd_q[0].tg[2];
          in_move_steps <= cmd_q[0].steps;
        end else begin
          in_valid <= 0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    pulse_wr_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pulse_q.size() == 0) begin
        $error("unexpected pulse leg %0d joint %0d pulse %0d", out_leg, out_joint,
               out_pulse_us);
        errors++;
      end else begin
        w = pulse_q.pop_front();
        if (out_leg !== w.leg) begin
          $error("out_leg expected %0d actual %0d", w.leg, out_leg); errors++;
        end
        if (out_joint !== w.joint) begin
          $error("out_joint expected %0d actual %0d", w.joint, out_joint); errors++;
        end
        if (out_pulse_us !== w.pulse) begin
          $error("pulse_us expected %0d actual %0d", w.pulse, out_pulse_us); errors++;
        end
        if (out_last_of_tick !== w.last) begin
          $error("last_of_tick expected %0d actual %0d", w.last, out_last_of_tick);
          errors++;
        end
      end
    end
  end

  initial begin
    cmd_t c;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    // directed: quiet-ish first tick, jumps, extremes, ignored fields on ticks
    cmd_q.push_back(make_tick());
    cmd_q.push_back(make_tick());
    c = make_move(0, 0);
    c.st = '{16'd0, 16'd46080, 16'hFFFF}; c.tg = '{16'hFFFF, 16'd0, 16'd46080};
    cmd_q.push_back(c);
    cmd_q.push_back(make_tick());
    cmd_q.push_back(make_tick());
    c = make_move(1, 1);
    cmd_q.push_back(c);
    cmd_q.push_back(make_tick());
    c = make_move(2, 4);
    c.st = '{16'd0, 16'd46080, 16'd23040}; c.tg = '{16'd46080, 16'd0, 16'd23040};
    cmd_q.push_back(c);
    c = make_move(3, 2);
    cmd_q.push_back(c);
    repeat (5) cmd_q.push_back(make_tick());
    c = make_move(0, 65535);
    cmd_q.push_back(c);
    repeat (2) cmd_q.push_back(make_tick());
    c = make_move(0, 3);
    cmd_q.push_back(c);
    repeat (4) cmd_q.push_back(make_tick());
    // random: mostly ticks with moves mixed in, a few long moves
    for (int n = 0; n < 100; n++) begin
      if ($urandom_range(0, 2) == 0)
        cmd_q.push_back(make_move($urandom_range(0, 3),
                                  ($urandom_range(0, 19) == 0) ? $urandom :
                                  $urandom_range(0, 8)));
      else
        cmd_q.push_back(make_tick());
      if (n == 33) begin
        wait (cmd_q.size() == 0);
        send_idle = 52; recv_idle = 22;
      end
      if (n == 66) begin
        wait (cmd_q.size() == 0);
        send_idle = 0; recv_idle = 0;
      end
    end
    wait (cmd_q.size() == 0 && !in_valid);
    wait (pulse_q.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && pulse_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mjp_pkg.sv
rtl/core/mjp_div.sv
rtl/core/min_jerk_servo_pulse_planner_core.sv
test/tb_min_jerk_servo_pulse_planner_core.sv
